[rtl/tbh_pkg.sv]
package tbh_pkg;

  localparam logic [31:0] TEA_DELTA    = 32'h9e37_79b9;
  localparam logic [31:0] SAVED_D_INIT = 32'h0008_f000;
  localparam int unsigned ROUNDS_PER_PASS = 32;
  localparam int unsigned TBH_QUEUE_DEPTH = 2;

  localparam int unsigned ROUND_W = $clog2(ROUNDS_PER_PASS);

  // register indexes on the config port
  localparam logic REG_SEED_FIRST  = 1'b0;
  localparam logic REG_SEED_SECOND = 1'b1;

  typedef enum logic [1:0] {
    KIND_OPEN,        // no data, not last: opens the message only
    KIND_CLOSE,       // no data, last: ends the message
    KIND_BLOCK,       // one block, message continues
    KIND_BLOCK_LAST   // one block, then result
  } item_kind_t;

  typedef struct packed {
    item_kind_t  kind;
    logic [31:0] word_low;
    logic [31:0] word_high;
  } tbh_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_EMIT
  } back_state_t;

  // one half of a TEA round: the term added to the other word
  function automatic logic [31:0] tea_mix(input logic [31:0] v,
                                          input logic [31:0] sum,
                                          input logic [31:0] ka,
                                          input logic [31:0] kb);
    tea_mix = (v + sum) ^ ((v << 4) + ka) ^ ((v >> 5) + kb);
  endfunction

endpackage

[rtl/tbh_front.sv]
module tbh_front
  import tbh_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = TBH_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_word_low,
  input  logic [31:0] in_word_high,
  input  logic        in_has_data,
  input  logic        in_last,
  output logic        q_valid,
  output tbh_item_t   q_item,
  input  logic        q_pop
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  tbh_item_t        mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;
  logic             pop;
  tbh_item_t        item;

  always_comb begin
    item.word_low  = in_word_low;
    item.word_high = in_word_high;
    unique case ({in_has_data, in_last})
      2'b00:   item.kind = KIND_OPEN;
      2'b01:   item.kind = KIND_CLOSE;
      2'b10:   item.kind = KIND_BLOCK;
      default: item.kind = KIND_BLOCK_LAST;
    endcase
  end

  assign in_ready = (count_r != CNT_FULL);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= item;
    end
  end

endmodule

[rtl/tbh_back.sv]
module tbh_back
  import tbh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] seed_first,
  input  logic [31:0] seed_second,
  input  logic        q_valid,
  input  tbh_item_t   q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_hash_word0,
  output logic [31:0] out_hash_word1,
  output logic [31:0] out_hash_word2,
  output logic [31:0] out_hash_word3
);

  back_state_t state_r, state_nxt;
  logic        in_msg_r, in_msg_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [ROUND_W-1:0] rnd_r, rnd_nxt;
  logic        pass_r, pass_nxt;
  logic        last_r, last_nxt;
  logic [31:0] a_r, a_nxt, b_r, b_nxt, c_r, c_nxt, d_r, d_nxt;
  logic [31:0] x_r, x_nxt, y_r, y_nxt;
  logic [31:0] sum_r, sum_nxt;
  logic [31:0] w0_r, w0_nxt, w1_r, w1_nxt;
  logic [31:0] h0_r, h0_nxt, h1_r, h1_nxt, h2_r, h2_nxt, h3_r, h3_nxt;
  logic [31:0] a0, b0, c0, d0;
  logic [31:0] x_new, y_new;
  logic        out_free;

  // start-of-message values: seeds are sampled only when a message opens
  assign a0 = in_msg_r ? a_r : seed_first;
  assign b0 = in_msg_r ? b_r : seed_second;
  assign c0 = in_msg_r ? c_r : seed_second;
  assign d0 = in_msg_r ? d_r : SAVED_D_INIT;

  assign x_new = x_r + tea_mix(y_r, sum_r, a_r, b_r);
  assign y_new = y_r + tea_mix(x_new, sum_r, w0_r, w1_r);

  assign out_free = !out_valid_r || out_ready;
  assign q_pop    = (state_r == ST_IDLE) && q_valid;

  assign out_valid      = out_valid_r;
  assign out_hash_word0 = h0_r;
  assign out_hash_word1 = h1_r;
  assign out_hash_word2 = h2_r;
  assign out_hash_word3 = h3_r;

  always_comb begin
    state_nxt     = state_r;
    in_msg_nxt    = in_msg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    rnd_nxt       = rnd_r;
    pass_nxt      = pass_r;
    last_nxt      = last_r;
    a_nxt = a_r; b_nxt = b_r; c_nxt = c_r; d_nxt = d_r;
    x_nxt = x_r; y_nxt = y_r;
    sum_nxt = sum_r;
    w0_nxt = w0_r; w1_nxt = w1_r;
    h0_nxt = h0_r; h1_nxt = h1_r; h2_nxt = h2_r; h3_nxt = h3_r;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          a_nxt      = a0;
          b_nxt      = b0;
          c_nxt      = c0;
          d_nxt      = d0;
          in_msg_nxt = 1'b1;
          x_nxt      = a0;
          y_nxt      = b0;
          sum_nxt    = TEA_DELTA;
          rnd_nxt    = '0;
          pass_nxt   = 1'b0;
          w0_nxt     = q_item.word_low;
          w1_nxt     = q_item.word_high;
          last_nxt   = (q_item.kind == KIND_BLOCK_LAST);
          unique case (q_item.kind)
            KIND_OPEN:       state_nxt = ST_IDLE;
            KIND_CLOSE:      state_nxt = ST_EMIT;
            KIND_BLOCK:      state_nxt = ST_RUN;
            KIND_BLOCK_LAST: state_nxt = ST_RUN;
            default:         state_nxt = ST_IDLE;
          endcase
        end
      end

      ST_RUN: begin
        x_nxt   = x_new;
        y_nxt   = y_new;
        sum_nxt = sum_r + TEA_DELTA;
        rnd_nxt = rnd_r + 1'b1;
        if (rnd_r == ROUND_W'(ROUNDS_PER_PASS - 1)) begin
          // end of pass: A<->C, B<->D with the pass output going to C,D
          a_nxt = c_r;
          b_nxt = d_r;
          c_nxt = x_new;
          d_nxt = y_new;
          if (!pass_r) begin
            x_nxt    = c_r;
            y_nxt    = d_r;
            sum_nxt  = TEA_DELTA;
            pass_nxt = 1'b1;
          end else begin
            state_nxt = last_r ? ST_EMIT : ST_IDLE;
          end
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          h0_nxt        = a_r;
          h1_nxt        = b_r;
          h2_nxt        = c_r;
          h3_nxt        = d_r;
          out_valid_nxt = 1'b1;
          in_msg_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_msg_r    <= 1'b0;
      out_valid_r <= 1'b0;
      rnd_r       <= '0;
      pass_r      <= 1'b0;
      last_r      <= 1'b0;
      a_r         <= '0;
      b_r         <= '0;
      c_r         <= '0;
      d_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      in_msg_r    <= in_msg_nxt;
      out_valid_r <= out_valid_nxt;
      rnd_r       <= rnd_nxt;
      pass_r      <= pass_nxt;
      last_r      <= last_nxt;
      a_r         <= a_nxt;
      b_r         <= b_nxt;
      c_r         <= c_nxt;
      d_r         <= d_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    sum_r <= sum_nxt;
    w0_r  <= w0_nxt;
    w1_r  <= w1_nxt;
    h0_r  <= h0_nxt;
    h1_r  <= h1_nxt;
    h2_r  <= h2_nxt;
    h3_r  <= h3_nxt;
  end

endmodule

[rtl/tea_block_hash_unit.sv]
// Channel   | Handshake          | Payload
// ----------+--------------------+-------------------------------------------
// input     | in_valid/in_ready  | in_word_low, in_word_high, in_has_data,
//           |                    | in_last
// result    | out_valid/out_ready| out_hash_word0..out_hash_word3
// config    | APB psel/penable   | seed_first @0x0, seed_second @0x4
//
// A block item is dequeued, then runs two passes of 32 TEA rounds in the
// round engine, one TEA round per cycle. An item without data runs no
// rounds; a result passes through the emit state into the output
// register. The input queue takes items while not full as the engine works.
// Reset is synchronous on rst_n; no clearing pass. A stalled result stops
// the engine only when the next result is due.
module tea_block_hash_unit
  import tbh_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = TBH_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_word_low,
  input  logic [31:0] in_word_high,
  input  logic        in_has_data,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_hash_word0,
  output logic [31:0] out_hash_word1,
  output logic [31:0] out_hash_word2,
  output logic [31:0] out_hash_word3,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] seed_first_r;
  logic [31:0] seed_second_r;
  logic        cfg_write;
  logic        reg_sel;
  logic        q_valid;
  logic        q_pop;
  tbh_item_t   q_item;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (reg_sel == REG_SEED_SECOND) ? seed_second_r : seed_first_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_first_r  <= '0;
      seed_second_r <= '0;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_SEED_FIRST:  seed_first_r  <= pwdata;
        REG_SEED_SECOND: seed_second_r <= pwdata;
        default: ;
      endcase
    end
  end

  tbh_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_word_low  (in_word_low),
    .in_word_high (in_word_high),
    .in_has_data  (in_has_data),
    .in_last      (in_last),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  tbh_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .seed_first     (seed_first_r),
    .seed_second    (seed_second_r),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hash_word0 (out_hash_word0),
    .out_hash_word1 (out_hash_word1),
    .out_hash_word2 (out_hash_word2),
    .out_hash_word3 (out_hash_word3)
  );

endmodule
